>>> hdl/pfp_pkg.sv
package pfp_pkg;

   localparam int PARAMS_PER_GROUP_DEF = 10;
   localparam int GROUP_COUNT_DEF      = 3;
   localparam int PAYLOAD_MAX_DEF      = 11;

   // widest table address for the largest legal group/parameter counts
   localparam int TAB_ADDR_W = 7;
   localparam int RSP_DATA_W = 56;

   localparam logic [7:0] HDR1       = 8'hAA;
   localparam logic [7:0] HDR2       = 8'h55;
   localparam logic [7:0] TYPE_QUERY = 8'd9;
   localparam logic [7:0] TYPE_DIST  = 8'd33;
   localparam logic [7:0] REPLY_LEN  = 8'd3;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_PARAM = 2'd1;
   localparam logic [1:0] EV_DIST  = 2'd2;
   localparam logic [1:0] EV_REPLY = 2'd3;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam logic [1:0] CMD_DIST  = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   typedef struct packed {
      logic [1:0]            kind;
      logic [7:0]            grp;
      logic [3:0]            index;
      logic [15:0]           value;
      logic [TAB_ADDR_W-1:0] addr;
   } cmd_type;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [7:0]  grp,
      input logic [3:0]  idx,
      input logic [15:0] val,
      input logic [7:0]  sum,
      input logic [15:0] distance
   );
      return {4'b0000, distance, sum, val, idx, grp};
   endfunction

endpackage

>>> hdl/pfp_ram.sv
module pfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 30
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pfp_front.sv
module pfp_front #(
   parameter int PARAMS_PER_GROUP = pfp_pkg::PARAMS_PER_GROUP_DEF,
   parameter int GROUP_COUNT      = pfp_pkg::GROUP_COUNT_DEF,
   parameter int PAYLOAD_MAX      = pfp_pkg::PAYLOAD_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   output logic             push_valid,
   input  logic             push_ready,
   output pfp_pkg::cmd_type push_data
);
   import pfp_pkg::*;

   localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

   localparam logic [2:0] PH_HDR1  = 3'd0;
   localparam logic [2:0] PH_HDR2  = 3'd1;
   localparam logic [2:0] PH_TYPE  = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_PAY   = 3'd4;
   localparam logic [2:0] PH_STORE = 3'd5;
   localparam logic [2:0] PH_QRY   = 3'd6;
   localparam logic [2:0] PH_DIST  = 3'd7;

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       pay_ff [PAYLOAD_MAX];
   logic [7:0]       pay_in [PAYLOAD_MAX];

   logic             accept;
   logic [7:0]       b;
   logic [7:0]       sum_add;
   logic             sum_ok;
   logic [11:0]      st_pos;
   logic [11:0]      q_pos;
   cmd_type          cmd;

   assign accept     = req_tvalid && push_ready;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign push_data  = cmd;
   assign b          = req_tdata;
   assign sum_add    = sum_ff + b;
   assign sum_ok     = (b == sum_ff);

   // table positions are taken from zero: (p0 - 1) + (type - 1) * group size
   assign st_pos = 12'(pay_ff[0]) - 12'd1
                 + (12'(type_ff) - 12'd1) * 12'(PARAMS_PER_GROUP);
   assign q_pos  = (12'(pay_ff[0]) - 12'd1) * 12'(PARAMS_PER_GROUP);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      sum_in   = sum_ff;
      for (int i = 0; i < PAYLOAD_MAX; i++) begin
         pay_in[i] = pay_ff[i];
      end
      cmd      = '0;
      cmd.kind = CMD_NONE;

      unique case (phase_ff)
         PH_HDR1: begin
            count_in = '0;
            len_in   = '0;
            type_in  = '0;
            sum_in   = '0;
            if (b == HDR1) begin
               phase_in = PH_HDR2;
               sum_in   = HDR1;
            end
         end
         PH_HDR2: begin
            if (b == HDR2) begin
               phase_in = PH_TYPE;
               sum_in   = sum_add;
            end else begin
               phase_in = PH_HDR1;
               count_in = '0;
            end
         end
         PH_TYPE: begin
            if (b != 8'd0) begin
               type_in  = b;
               phase_in = PH_LEN;
               sum_in   = sum_add;
            end else begin
               phase_in = PH_HDR1;
               count_in = '0;
            end
         end
         PH_LEN: begin
            if (b >= 8'd1 && b <= 8'(PAYLOAD_MAX)) begin
               len_in   = CNT_W'(b);
               phase_in = PH_PAY;
               count_in = '0;
               sum_in   = sum_add;
            end else begin
               phase_in = PH_HDR1;
               count_in = '0;
            end
         end
         PH_PAY: begin
            for (int i = 0; i < PAYLOAD_MAX; i++) begin
               if (count_ff == CNT_W'(i)) begin
                  pay_in[i] = b;
               end
            end
            count_in = count_ff + 1'b1;
            sum_in   = sum_add;
            if (count_in == len_ff) begin
               if (type_ff >= 8'd1 && type_ff <= 8'(GROUP_COUNT)) begin
                  phase_in = PH_STORE;
               end else if (type_ff == TYPE_QUERY) begin
                  phase_in = PH_QRY;
               end else if (type_ff == TYPE_DIST) begin
                  phase_in = PH_DIST;
               end else begin
                  phase_in = PH_HDR1;
                  count_in = '0;
               end
            end
         end
         PH_STORE: begin
            if (sum_ok && pay_ff[0] >= 8'd1 && pay_ff[0] <= 8'(PARAMS_PER_GROUP)) begin
               cmd.kind  = CMD_STORE;
               cmd.grp   = type_ff;
               cmd.index = pay_ff[0][3:0];
               cmd.value = {pay_ff[1], pay_ff[2]};
               cmd.addr  = st_pos[TAB_ADDR_W-1:0];
            end
            phase_in = PH_HDR1;
            count_in = '0;
         end
         PH_QRY: begin
            if (sum_ok && pay_ff[0] >= 8'd1 && pay_ff[0] <= 8'(GROUP_COUNT)) begin
               cmd.kind = CMD_QUERY;
               cmd.grp  = pay_ff[0];
               cmd.addr = q_pos[TAB_ADDR_W-1:0];
            end
            phase_in = PH_HDR1;
            count_in = '0;
         end
         PH_DIST: begin
            if (sum_ok) begin
               cmd.kind  = CMD_DIST;
               cmd.grp   = TYPE_DIST;
               cmd.value = {pay_ff[0], pay_ff[1]};
            end
            phase_in = PH_HDR1;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR1;
         count_ff <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < PAYLOAD_MAX; i++) begin
            pay_ff[i] <= '0;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         sum_ff   <= sum_in;
         for (int i = 0; i < PAYLOAD_MAX; i++) begin
            pay_ff[i] <= pay_in[i];
         end
      end
   end

endmodule

>>> hdl/pfp_cmd_fifo.sv
module pfp_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pfp_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pfp_pkg::cmd_type pop_data
);
   import pfp_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff ^ do_push;
      rd_in  = rd_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hdl/pfp_back.sv
module pfp_back #(
   parameter int PARAMS_PER_GROUP = pfp_pkg::PARAMS_PER_GROUP_DEF,
   parameter int GROUP_COUNT      = pfp_pkg::GROUP_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  pfp_pkg::cmd_type               pop_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast
);
   import pfp_pkg::*;

   localparam int TABLE_DEPTH = GROUP_COUNT * PARAMS_PER_GROUP;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NUM_W       = $clog2(PARAMS_PER_GROUP + 1);

   localparam logic B_IDLE = 1'b0;
   localparam logic B_READ = 1'b1;

   logic                  st_ff, st_in;
   logic [7:0]            grp_ff, grp_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [15:0]           dist_ff, dist_in;
   logic [TABLE_DEPTH-1:0] vld_ff, vld_in;
   logic                  vrd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     rd_addr, cmd_addr;
   logic [15:0]           rd_data, rd_val;
   logic [7:0]            idx8, rep_sum;

   pfp_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_addr),
      .wr_data (pop_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cmd_addr = pop_data.addr[ADDR_W-1:0];
   // entries never written read as zero
   assign rd_val   = vrd_ff ? rd_data : 16'd0;
   assign idx8     = 8'(num_ff) + 8'd1;
   assign rep_sum  = HDR1 + HDR2 + grp_ff + REPLY_LEN + idx8 + rd_val[15:8] + rd_val[7:0];

   always_comb begin
      st_in        = st_ff;
      grp_in       = grp_ff;
      addr_in      = addr_ff;
      num_in       = num_ff;
      dist_in      = dist_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      pop_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;

      unique case (st_ff)
         B_IDLE: begin
            if (pop_valid) begin
               if (pop_data.kind == CMD_QUERY) begin
                  pop_ready = 1'b1;
                  rd_en     = 1'b1;
                  rd_addr   = cmd_addr;
                  addr_in   = cmd_addr;
                  num_in    = '0;
                  grp_in    = pop_data.grp;
                  st_in     = B_READ;
               end else if (out_free) begin
                  pop_ready    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  case (pop_data.kind)
                     CMD_STORE: begin
                        wr_en            = 1'b1;
                        vld_in[cmd_addr] = 1'b1;
                        rsp_user_in      = EV_PARAM;
                        rsp_data_in      = pack_rsp(pop_data.grp, pop_data.index,
                                                    pop_data.value, 8'd0, dist_ff);
                     end
                     CMD_DIST: begin
                        dist_in     = pop_data.value;
                        rsp_user_in = EV_DIST;
                        rsp_data_in = pack_rsp(TYPE_DIST, 4'd0, 16'd0, 8'd0,
                                               pop_data.value);
                     end
                     default: begin
                        rsp_user_in = EV_NONE;
                        rsp_data_in = pack_rsp(8'd0, 4'd0, 16'd0, 8'd0, dist_ff);
                     end
                  endcase
               end
            end
         end
         B_READ: begin
            // emit one reply and fetch the next entry in the same cycle
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = EV_REPLY;
               rsp_data_in  = pack_rsp(grp_ff, idx8[3:0], rd_val, rep_sum, dist_ff);
               rsp_last_in  = (num_ff == NUM_W'(PARAMS_PER_GROUP - 1));
               if (rsp_last_in) begin
                  st_in = B_IDLE;
               end else begin
                  num_in  = num_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(addr_ff + 1'b1);
                  addr_in = rd_addr;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      addr_ff     <= addr_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (rd_en) begin
         vrd_ff <= vld_ff[rd_addr];
      end
      if (reset) begin
         st_ff        <= B_IDLE;
         dist_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         dist_ff      <= dist_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/framed_param_packet_parser_core.sv
// Channel  Dir  Payload
// req_     in   tdata: rx_byte
// rsp_     out  tuser: event_res; tdata: group..distance; tlast: last
//
// The parser takes one byte a cycle while its two-entry command queue has room;
// every byte gives exactly one command. The executor issues a stored, distance or
// empty result as a single result, and a query as PARAMS_PER_GROUP replies, read in
// turn through the single read port of the parameter table.
// Reset is synchronous; it clears the parser, the queue, the distance and the
// table's valid bits at once, so the block is ready on the next cycle.
// A stall on rsp_ holds the executor; the parser runs on until the queue fills.
module framed_param_packet_parser_core #(
   parameter int PARAMS_PER_GROUP = pfp_pkg::PARAMS_PER_GROUP_DEF,
   parameter int GROUP_COUNT      = pfp_pkg::GROUP_COUNT_DEF,
   parameter int PAYLOAD_MAX      = pfp_pkg::PAYLOAD_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] group, [11:8] param_index, [27:12] param_value, [35:28] reply_sum,
   // [51:36] distance, [55:52] zero
   output logic [pfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // [1:0] event_res
   output logic                           rsp_tlast
);
   import pfp_pkg::*;

   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   cmd_type push_data, pop_data;

   pfp_front #(
      .PARAMS_PER_GROUP (PARAMS_PER_GROUP),
      .GROUP_COUNT      (GROUP_COUNT),
      .PAYLOAD_MAX      (PAYLOAD_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pfp_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pfp_back #(
      .PARAMS_PER_GROUP (PARAMS_PER_GROUP),
      .GROUP_COUNT      (GROUP_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // only a reply burst spans several results
   a_single_not_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_REPLY) |-> rsp_tlast)
      else $error("non-reply result without last");

   a_none_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_NONE) |-> (rsp_tdata[35:0] == 36'd0))
      else $error("empty result carries data");

   a_dist_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_DIST) |->
         (rsp_tdata[7:0] == TYPE_DIST && rsp_tdata[35:8] == 28'd0))
      else $error("distance result fields wrong");

   // a request is only taken when the queue can hold its command
   a_req_queued: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (push_valid && push_ready))
      else $error("request accepted without queue entry");

endmodule
